/* hdl/srs_pkg.sv */
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the selective-repeat sender window.
// ----------------------------------------------------------------------------
package srs_pkg;

  localparam int unsigned SeqW      = 3;   // sequence number bits (space of 8)
  localparam int unsigned DataW     = 32;  // payload bits
  localparam int unsigned FuncW     = 2;
  localparam int unsigned InTdataW  = 40;  // payload, ack_num, ack_ok, timeout_seq
  localparam int unsigned OutTdataW = 48;  // ten result fields, zero padded

  typedef enum logic [FuncW-1:0] {
    FuncSend    = 2'd0,
    FuncAck     = 2'd1,
    FuncTimeout = 2'd2,
    FuncRsvd    = 2'd3   // unused code: status fields only
  } srs_func_e;

  typedef enum logic {
    StIdle,
    StExec
  } srs_state_e;

  // controller to datapath
  typedef struct packed {
    logic capture;  // latch the input transaction
    logic commit;   // update window state and load the result register
  } srs_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic res_free;  // result register empty or draining this cycle
  } srs_stat_t;

  typedef struct packed {
    logic            send_accepted;
    logic            tx_valid;
    logic [SeqW-1:0] tx_seq;
    logic [DataW-1:0] tx_payload;
    logic            timer_start;
    logic            timer_stop;
    logic [SeqW-1:0] timer_seq;
    logic            stop_all_timers;
    logic            window_full;
    logic [SeqW-1:0] in_flight;
  } srs_result_t;

endpackage

/* hdl/srs_ctrl.sv */
// ----------------------------------------------------------------------------
// srs_ctrl
// Two-state sequencer: take one transaction, then commit it to the datapath.
// ----------------------------------------------------------------------------
module srs_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  srs_pkg::srs_stat_t stat_i,
  output srs_pkg::srs_cmd_t  cmd_o
);
  import srs_pkg::*;

  srs_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: begin
        if (in_valid_i) state_d = StExec;
      end
      StExec: begin
        if (stat_i.res_free) state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    cmd_o.capture = 1'b0;
    cmd_o.commit  = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      StExec: begin
        // hold while an unread result blocks the output register
        cmd_o.commit = stat_i.res_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/srs_datapath.sv */
// ----------------------------------------------------------------------------
// srs_datapath
// Window slots, sequence pointers, event execution and the result register.
// ----------------------------------------------------------------------------
module srs_datapath #(
  parameter int unsigned WINDOW_SIZE = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  srs_pkg::srs_cmd_t               cmd_i,
  output srs_pkg::srs_stat_t              stat_o,
  input  logic [srs_pkg::InTdataW-1:0]    tdata_i,
  input  logic [srs_pkg::FuncW-1:0]       tuser_i,
  input  logic                            res_ready_i,
  output logic                            res_valid_o,
  output srs_pkg::srs_result_t            res_o
);
  import srs_pkg::*;

  localparam int unsigned IdxW = $clog2(WINDOW_SIZE);
  localparam int unsigned CntW = $clog2(WINDOW_SIZE + 1);
  localparam int unsigned SumW = CntW + 1;
  localparam logic [CntW-1:0] WinMax = CntW'(WINDOW_SIZE);

  // latched transaction
  srs_func_e        func_q;
  logic [DataW-1:0] payload_q;
  logic [SeqW-1:0]  ack_num_q;
  logic             ack_ok_q;
  logic [SeqW-1:0]  tseq_q;

  // window state
  logic [SeqW-1:0]  slot_seq_q  [WINDOW_SIZE];
  logic [SeqW-1:0]  slot_seq_d  [WINDOW_SIZE];
  logic [DataW-1:0] slot_data_q [WINDOW_SIZE];
  logic [DataW-1:0] slot_data_d [WINDOW_SIZE];
  logic [WINDOW_SIZE-1:0] acked_q, acked_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [SeqW-1:0]  base_q, base_d;
  logic [SeqW-1:0]  next_q, next_d;
  logic             full_q, full_d;

  srs_result_t      res_q, res_d;
  logic             res_valid_q, res_valid_d;

  // helpers
  logic [WINDOW_SIZE-1:0] lead_acked;
  logic [CntW-1:0]  slide;
  logic             run;
  logic [SumW-1:0]  src;
  logic [SeqW-1:0]  to_idx;
  logic             to_hit;
  logic [IdxW-1:0]  to_slot;
  logic [IdxW-1:0]  wr_idx;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q    <= srs_func_e'(tuser_i);
      payload_q <= tdata_i[DataW-1:0];
      ack_num_q <= tdata_i[DataW +: SeqW];
      ack_ok_q  <= tdata_i[DataW + SeqW];
      tseq_q    <= tdata_i[DataW + SeqW + 1 +: SeqW];
    end
  end

  // leading run of acked slots once the base counts as acked
  always_comb begin
    lead_acked    = acked_q;
    lead_acked[0] = 1'b1;
    slide         = '0;
    run           = 1'b1;
    for (int i = 0; i < WINDOW_SIZE; i++) begin
      if (run && (CntW'(i) < count_q) && lead_acked[i]) begin
        slide = slide + CntW'(1);
      end else begin
        run = 1'b0;
      end
    end
  end

  assign to_idx  = tseq_q - base_q;
  assign to_hit  = to_idx < SeqW'(count_q);
  assign to_slot = to_idx[IdxW-1:0];
  assign wr_idx  = count_q[IdxW-1:0];

  always_comb begin
    slot_seq_d  = slot_seq_q;
    slot_data_d = slot_data_q;
    acked_d     = acked_q;
    count_d     = count_q;
    base_d      = base_q;
    next_d      = next_q;
    full_d      = full_q;
    res_d       = '0;
    src         = '0;
    case (func_q)
      FuncSend: begin
        if (!full_q && (count_q < WinMax)) begin
          slot_seq_d[wr_idx]  = next_q;
          slot_data_d[wr_idx] = payload_q;
          acked_d[wr_idx]     = 1'b0;
          res_d.send_accepted = 1'b1;
          res_d.tx_valid      = 1'b1;
          res_d.tx_seq        = next_q;
          res_d.tx_payload    = payload_q;
          res_d.timer_start   = 1'b1;
          res_d.timer_seq     = next_q;
          if (count_q == '0) base_d = next_q;
          next_d  = next_q + SeqW'(1);
          count_d = count_q + CntW'(1);
          if (count_d == WinMax) full_d = 1'b1;
        end
      end
      FuncAck: begin
        if (ack_ok_q && (count_q != '0)) begin
          if (ack_num_q != base_q) begin
            for (int i = 0; i < WINDOW_SIZE; i++) begin
              if ((CntW'(i) < count_q) && (slot_seq_q[i] == ack_num_q)) begin
                acked_d[i]       = 1'b1;
                res_d.timer_stop = 1'b1;
                res_d.timer_seq  = ack_num_q;
              end
            end
          end else begin
            res_d.timer_stop = 1'b1;
            res_d.timer_seq  = slot_seq_q[0];
            // slide the window past the leading acked slots
            for (int i = 0; i < WINDOW_SIZE; i++) begin
              src = SumW'(i) + SumW'(slide);
              if (src < SumW'(WINDOW_SIZE)) begin
                slot_seq_d[i]  = slot_seq_q[src[IdxW-1:0]];
                slot_data_d[i] = slot_data_q[src[IdxW-1:0]];
                acked_d[i]     = lead_acked[src[IdxW-1:0]];
              end else begin
                acked_d[i] = 1'b0;
              end
            end
            base_d  = base_q + SeqW'(slide);
            count_d = count_q - slide;
            full_d  = 1'b0;
            if (count_d == '0) res_d.stop_all_timers = 1'b1;
          end
        end
      end
      FuncTimeout: begin
        if (to_hit) begin
          acked_d[to_slot]  = 1'b0;
          res_d.tx_valid    = 1'b1;
          res_d.tx_seq      = slot_seq_q[to_slot];
          res_d.tx_payload  = slot_data_q[to_slot];
          res_d.timer_start = 1'b1;
          res_d.timer_seq   = tseq_q;
        end
      end
      default: begin
        res_d.send_accepted = 1'b0;
      end
    endcase
    res_d.window_full = full_d;
    res_d.in_flight   = SeqW'(count_d);
  end

  always_comb begin
    res_valid_d = res_valid_q;
    if (cmd_i.commit) begin
      res_valid_d = 1'b1;
    end else if (res_ready_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acked_q     <= '0;
      count_q     <= '0;
      base_q      <= '0;
      next_q      <= '0;
      full_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        acked_q <= acked_d;
        count_q <= count_d;
        base_q  <= base_d;
        next_q  <= next_d;
        full_q  <= full_d;
      end
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      slot_seq_q  <= slot_seq_d;
      slot_data_q <= slot_data_d;
      res_q       <= res_d;
    end
  end

  assign stat_o.res_free = !res_valid_q || res_ready_i;
  assign res_valid_o     = res_valid_q;
  assign res_o           = res_q;

endmodule

/* hdl/selective_repeat_sender_unit.sv */
// ----------------------------------------------------------------------------
// selective_repeat_sender_unit
// Flow: an accepted transaction is latched, then committed into the window and the
//   result register by the capture/commit sequencer; a new event is taken only after
//   the last one commits, and commit waits while the result register holds an untaken result.
// Reset: rst_ni clears the window, pointers, full flag and result valid at once.
// ----------------------------------------------------------------------------
module selective_repeat_sender_unit #(
  // slots in the send window, 2 to 7 (in_flight is three bits wide)
  parameter int unsigned WINDOW_SIZE = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // event stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  // [31:0] payload, [34:32] ack_num, [35] ack_ok, [38:36] timeout_seq, [39] zero
  input  logic [srs_pkg::InTdataW-1:0]  s_axis_tdata_i,
  // [1:0] func
  input  logic [srs_pkg::FuncW-1:0]     s_axis_tuser_i,
  // result stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  // [0] send_accepted, [1] tx_valid, [4:2] tx_seq, [36:5] tx_payload,
  // [37] timer_start, [38] timer_stop, [41:39] timer_seq, [42] stop_all_timers,
  // [43] window_full, [46:44] in_flight, [47] zero
  output logic [srs_pkg::OutTdataW-1:0] m_axis_tdata_o
);
  import srs_pkg::*;

  srs_cmd_t    cmd;
  srs_stat_t   stat;
  srs_result_t res;

  // Sequencer: IDLE takes a transaction, EXEC commits it into the window and
  // the result register. Input is accepted again while a result waits.
  srs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath: slot storage with sequence numbers, data and acked bits; the
  // base slot is always slot 0, an ack of the base slides the window.
  srs_datapath #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .tdata_i     (s_axis_tdata_i),
    .tuser_i     (s_axis_tuser_i),
    .res_ready_i (m_axis_tready_i),
    .res_valid_o (m_axis_tvalid_o),
    .res_o       (res)
  );

  // Pack result fields, first field in the lowest bits.
  assign m_axis_tdata_o = {1'b0,
                           res.in_flight,
                           res.window_full,
                           res.stop_all_timers,
                           res.timer_seq,
                           res.timer_stop,
                           res.timer_start,
                           res.tx_payload,
                           res.tx_seq,
                           res.tx_valid,
                           res.send_accepted};

endmodule

/* hdl/srs_checker.sv */
// ----------------------------------------------------------------------------
// srs_checker
// Port-level checks for the selective-repeat sender, bound to the top level.
// ----------------------------------------------------------------------------
module srs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid_i,
  input logic                          s_axis_tready_o,
  input logic                          m_axis_tvalid_o,
  input logic                          m_axis_tready_i,
  input logic [srs_pkg::OutTdataW-1:0] m_axis_tdata_o
);

  // one event at a time: no back-to-back accept
  a_one_per_two: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("input accepted on consecutive cycles");

  // stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("stalled result changed");

  // a packet on the wire always restarts its timer
  a_tx_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[1]) |-> (m_axis_tdata_o[37] && !m_axis_tdata_o[38]))
    else $error("transmit without timer start");

  // a full window is never empty
  a_full_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[43]) |-> (m_axis_tdata_o[46:44] != 3'd0))
    else $error("window full with nothing in flight");

  // stop-all only when the window reports empty
  a_stop_all_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tdata_o[42]) |-> (m_axis_tdata_o[46:44] == 3'd0))
    else $error("stop all timers with packets in flight");

endmodule

bind selective_repeat_sender_unit srs_checker u_srs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);
